// File: sv/odb_pkg.sv
// Shared types, constants and helpers for the OID DER body decoder.
// Used by odb_core, odb_result_queue and oid_der_body_decoder_top.
`default_nettype none

package odb_pkg;

  // Default width of the component accumulator.
  localparam int CompBitsDefault = 32;

  // Width of the component field of a result.
  localparam int CompOutBits = 32;

  // Multiplier and shift that turn an 8-bit division by 40 into a multiply.
  localparam logic [15:0] Div40Mul = 16'd205;
  localparam int Div40Shift = 13;
  localparam logic [7:0] FirstByteBase = 8'd40;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StTooLong    = 2'd1,
    StUnfinished = 2'd2
  } odb_status_t;

  // One decoded result transaction.
  typedef struct packed {
    logic [CompOutBits-1:0] component;
    odb_status_t            status;
    logic                   run_last;
    logic                   oid_end;
  } odb_result_t;

  // Up to two results produced by one accepted byte.
  typedef struct packed {
    logic [1:0]  count;
    odb_result_t r0;
    odb_result_t r1;
  } odb_push_t;

  // Quotient of an 8-bit value by 40 (0 to 6).
  function automatic logic [2:0] div40(input logic [7:0] b);
    logic [15:0] prod;
    prod = {8'd0, b} * Div40Mul;
    return prod[Div40Shift+2:Div40Shift];
  endfunction

  // Remainder of an 8-bit value by 40, given its quotient.
  function automatic logic [5:0] rem40(input logic [7:0] b, input logic [2:0] q);
    logic [7:0] diff;
    diff = b - ({5'd0, q} * FirstByteBase);
    return diff[5:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/odb_core.sv
// Byte decoder: holds the component state and turns each accepted byte
// into zero, one or two results. Depends on odb_pkg.
`default_nettype none

module odb_core #(
  parameter int COMPONENT_BITS = odb_pkg::CompBitsDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             start_byte,
  input  wire logic             final_byte,
  output odb_pkg::odb_push_t    push
);

  localparam int Limit = COMPONENT_BITS / 7;
  localparam int CntW  = $clog2(Limit + 1);
  localparam logic [CntW-1:0] LimitC = CntW'(Limit);

  logic [COMPONENT_BITS-1:0] accumulator, accumulator_next;
  logic [CntW-1:0]           byte_count, byte_count_next;
  logic                      pending_flag, pending_flag_next;
  logic                      discarding, discarding_next;

  logic [COMPONENT_BITS+6:0]  acc_wide;
  logic [COMPONENT_BITS-1:0]  acc_shift;
  logic [COMPONENT_BITS+31:0] comp_wide;
  logic [2:0]                 first_hi;
  logic [5:0]                 first_lo;
  odb_pkg::odb_push_t         push_c;

  // Shift the low seven bits of the byte into the accumulator.
  assign acc_wide  = {accumulator, data_byte[6:0]};
  assign acc_shift = acc_wide[COMPONENT_BITS-1:0];
  assign comp_wide = {32'd0, acc_shift};

  // The first byte splits into two components.
  assign first_hi = odb_pkg::div40(data_byte);
  assign first_lo = odb_pkg::rem40(data_byte, first_hi);

  // Next state and results for one byte.
  always_comb begin
    accumulator_next  = accumulator;
    byte_count_next   = byte_count;
    pending_flag_next = pending_flag;
    discarding_next   = discarding;
    push_c            = '0;
    push_c.r0.status  = odb_pkg::StOk;
    push_c.r1.status  = odb_pkg::StOk;
    priority if (start_byte) begin
      accumulator_next    = '0;
      byte_count_next     = '0;
      pending_flag_next   = 1'b0;
      discarding_next     = 1'b0;
      push_c.count        = 2'd2;
      push_c.r0.component = {29'd0, first_hi};
      push_c.r1.component = {26'd0, first_lo};
      push_c.r1.run_last  = 1'b1;
      push_c.r1.oid_end   = final_byte;
    end else if (discarding) begin
      if (final_byte) begin
        discarding_next = 1'b0;
      end
    end else if (byte_count >= LimitC) begin
      accumulator_next   = '0;
      byte_count_next    = '0;
      pending_flag_next  = 1'b0;
      discarding_next    = !final_byte;
      push_c.count       = 2'd1;
      push_c.r0.status   = odb_pkg::StTooLong;
      push_c.r0.run_last = 1'b1;
      push_c.r0.oid_end  = 1'b1;
    end else if (!data_byte[7]) begin
      accumulator_next    = '0;
      byte_count_next     = '0;
      pending_flag_next   = 1'b0;
      push_c.count        = 2'd1;
      push_c.r0.component = comp_wide[31:0];
      push_c.r0.run_last  = 1'b1;
      push_c.r0.oid_end   = final_byte;
    end else if (final_byte) begin
      accumulator_next   = '0;
      byte_count_next    = '0;
      pending_flag_next  = 1'b0;
      push_c.count       = 2'd1;
      push_c.r0.status   = odb_pkg::StUnfinished;
      push_c.r0.run_last = 1'b1;
      push_c.r0.oid_end  = 1'b1;
    end else begin
      accumulator_next  = acc_shift;
      byte_count_next   = byte_count + 1'b1;
      pending_flag_next = 1'b1;
    end
  end

  // Results only leave on an accepted byte.
  always_comb begin
    push = push_c;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  // Component state.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      byte_count   <= '0;
      pending_flag <= 1'b0;
      discarding   <= 1'b0;
    end else if (accept) begin
      accumulator  <= accumulator_next;
      byte_count   <= byte_count_next;
      pending_flag <= pending_flag_next;
      discarding   <= discarding_next;
    end
  end

  // An open component always has at least one byte counted.
  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    pending_flag == (byte_count != '0))
    else $error("pending flag disagrees with byte count");

  // While bytes are dropped no component is open.
  a_discard_clear: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (byte_count == '0 && accumulator == '0))
    else $error("component state left open while discarding");

  // The byte count never passes the length limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LimitC)
    else $error("byte count beyond limit");

endmodule

`default_nettype wire

// File: sv/odb_result_queue.sv
// Three-entry result queue: takes up to two results per cycle, gives one unless out_stall is high.
// Depends on odb_pkg.
`default_nettype none

module odb_result_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire odb_pkg::odb_push_t push,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output odb_pkg::odb_result_t    out_head
);

  odb_pkg::odb_result_t slot [3];
  logic [1:0] count, count_next;
  logic [1:0] base, base_plus;
  logic       pop;

  // Room is kept for a first byte's two results.
  assign full      = (count > 2'd1);
  assign out_valid = (count != 2'd0);
  assign out_head  = slot[0];
  assign pop       = out_valid && !out_stall;

  assign base       = count - {1'b0, pop};
  assign base_plus  = base + 2'd1;
  assign count_next = base + push.count;

  // Shift down on a transaction, then write new results behind the rest.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (push.count != 2'd0 && base == 2'(i)) begin
        slot[i] <= push.r0;
      end else if (push.count == 2'd2 && base_plus == 2'(i)) begin
        slot[i] <= push.r1;
      end else if (pop && i < 2) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Results are only written when room for two was there.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> !full)
    else $error("results written into a full queue");

  // A lone transaction out lowers the fill by one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> count == $past(count) - 2'd1)
    else $error("queue fill wrong after transaction");

endmodule

`default_nettype wire

// File: sv/oid_der_body_decoder_top.sv
// Decodes DER object identifier content bytes, one byte per transaction,
// into identifier components. A byte that produces one result or none is
// taken every cycle while the result queue is not full; a first byte produces
// two results and so stalls input until one of them has been taken. Input
// stall follows the fill of a three-entry result queue, which stalls input
// once two or more results are waiting; every result passes through it.
// Depends on odb_pkg, odb_core and odb_result_queue.
`default_nettype none

module oid_der_body_decoder_top #(
  parameter int COMPONENT_BITS = odb_pkg::CompBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_byte,
  input  wire logic        final_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      component,
  output logic [1:0]       status,
  output logic             run_last,
  output logic             oid_end
);

  odb_pkg::odb_push_t   push;
  odb_pkg::odb_result_t head;
  logic                 full;
  logic                 accept;

  // Input transaction.
  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  odb_core #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .start_byte (start_byte),
    .final_byte (final_byte),
    .push       (push)
  );

  odb_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_head  (head)
  );

  // Result fields.
  assign component = head.component;
  assign status    = head.status;
  assign run_last  = head.run_last;
  assign oid_end   = head.oid_end;

endmodule

`default_nettype wire

// File: bench/oid_der_body_decoder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for oid_der_body_decoder_top: a table of directed bytes,
// then random identifiers, scored against typed results or a bit-accurate decoder model.
// Depends on odb_pkg and the decoder RTL.

module oid_der_body_decoder_top_tb;

  localparam int CompBits = odb_pkg::CompBitsDefault;
  localparam int BitsPerByte = 7;
  localparam int Predicted = -1;
  localparam int RandomItems = 850;
  localparam int DrainLimit = 5000;
  localparam odb_pkg::odb_result_t NoResult = '0;

  // Receiver stall patterns, changed whenever stall_cycle wraps to zero.
  typedef enum logic [1:0] {
    StallNone  = 2'd0,
    StallLight = 2'd1,
    StallHeavy = 2'd2,
    StallRuns  = 2'd3
  } stall_mode_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic [7:0]           data;
    logic                 first;
    logic                 last;
    int                   typed_n;
    odb_pkg::odb_result_t r0;
    odb_pkg::odb_result_t r1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        start_byte = 1'b0;
  logic        final_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] component;
  logic [1:0]  status;
  logic        run_last;
  logic        oid_end;

  // Model state of the decoder.
  logic [CompBits-1:0] comp_acc = '0;
  int unsigned         comp_bytes = 0;
  bit                  dropping = 1'b0;

  odb_pkg::odb_result_t decoded_q[$];
  stim_row_t            dir_rows[$];
  odb_pkg::odb_result_t want;
  int          errors = 0;
  int          items_done = 0;
  int          burst_left = 0;
  int          drain_cycles;
  stall_mode_t stall_mode = StallNone;
  logic [7:0]  stall_cycle = 8'd0;
  int          stall_run = 0;

  oid_der_body_decoder_top u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .start_byte   (start_byte),
    .final_byte   (final_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .component    (component),
    .status       (status),
    .run_last     (run_last),
    .oid_end      (oid_end)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(5_000_000);
    $display("oid_der_body_decoder_top: mismatch");
    $finish;
  end

  function automatic odb_pkg::odb_result_t make_result(input logic [31:0] c,
                                                       input odb_pkg::odb_status_t s,
                                                       input logic rl, input logic oe);
    odb_pkg::odb_result_t r;
    r.component = c;
    r.status = s;
    r.run_last = rl;
    r.oid_end = oe;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Decodes one accepted byte, updates the model state and returns the number of results.
  function automatic int decode_oid_byte(input logic [7:0] b, input logic f, input logic l,
                                         output odb_pkg::odb_result_t r0,
                                         output odb_pkg::odb_result_t r1,
                                         output bit ignored);
    logic [7:0] quo;
    r0 = NoResult;
    r1 = NoResult;
    ignored = 1'b0;
    // A first byte restarts the identifier and splits into two arcs.
    if (f) begin
      quo = b / odb_pkg::FirstByteBase;
      comp_acc = '0;
      comp_bytes = 0;
      dropping = 1'b0;
      r0 = make_result(32'(quo), odb_pkg::StOk, 1'b0, 1'b0);
      r1 = make_result(32'(b - quo * odb_pkg::FirstByteBase), odb_pkg::StOk, 1'b1, l);
      return 2;
    end
    // The rest of a failed identifier is dropped up to its final byte.
    if (dropping) begin
      ignored = 1'b1;
      if (l) dropping = 1'b0;
      return 0;
    end
    comp_bytes++;
    if (comp_bytes * BitsPerByte > CompBits) begin
      comp_acc = '0;
      comp_bytes = 0;
      dropping = !l;
      r0 = make_result(32'd0, odb_pkg::StTooLong, 1'b1, 1'b1);
      return 1;
    end
    comp_acc = (comp_acc << BitsPerByte) | CompBits'(b[6:0]);
    // A clear top bit closes the component.
    if (!b[7]) begin
      r0 = make_result(32'(comp_acc), odb_pkg::StOk, 1'b1, l);
      comp_acc = '0;
      comp_bytes = 0;
      return 1;
    end
    if (l) begin
      comp_acc = '0;
      comp_bytes = 0;
      r0 = make_result(32'd0, odb_pkg::StUnfinished, 1'b1, 1'b1);
      return 1;
    end
    return 0;
  endfunction

  // Sends one byte transaction in bursts, with gaps except in StallNone mode, then records what it should produce.
  task automatic push_byte(input logic [7:0] b, input logic f, input logic l,
                           input int typed_n, input odb_pkg::odb_result_t t0,
                           input odb_pkg::odb_result_t t1);
    odb_pkg::odb_result_t p0;
    odb_pkg::odb_result_t p1;
    int n;
    int gap;
    bit ignored;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (stall_mode == StallNone) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    start_byte <= f;
    final_byte <= l;
    @(posedge clk);
    while (byte_stall !== 1'b0) @(posedge clk);
    burst_left--;
    n = decode_oid_byte(b, f, l, p0, p1, ignored);
    if (typed_n != Predicted) begin
      n = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) decoded_q.insert(decoded_q.size(), p0);
    if (n > 1) decoded_q.insert(decoded_q.size(), p1);
    if (!ignored) items_done++;
  endtask

  task automatic add_row(input logic [7:0] b, input logic f, input logic l, input int n,
                         input odb_pkg::odb_result_t r0, input odb_pkg::odb_result_t r1);
    stim_row_t row;
    row.data = b;
    row.first = f;
    row.last = l;
    row.typed_n = n;
    row.r0 = r0;
    row.r1 = r1;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Sends one random identifier: mostly well formed, sometimes broken or pure noise.
  task automatic send_random_oid();
    logic [7:0] body[$];
    int kind;
    int ncomp;
    int len;
    int bad_at;
    bit skip_first;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 4))
        push_byte(8'($urandom), 1'($urandom), 1'($urandom), Predicted, NoResult, NoResult);
      return;
    end
    skip_first = (kind == 8);
    body.insert(body.size(), 8'($urandom_range(0, 255)));
    ncomp = (kind == 7) ? $urandom_range(1, 6) : $urandom_range(0, 6);
    bad_at = (kind == 7) ? $urandom_range(0, ncomp - 1) : -1;
    for (int c = 0; c < ncomp; c++) begin
      len = (c == bad_at) ? $urandom_range(5, 7) : $urandom_range(1, 4);
      for (int j = 0; j < len; j++) body.insert(body.size(), {j != len - 1, 7'($urandom)});
    end
    // An identifier that stops inside a component.
    if (kind == 6) body.insert(body.size(), {1'b1, 7'($urandom)});
    foreach (body[i])
      push_byte(body[i], (i == 0) && !skip_first, i == body.size() - 1,
                Predicted, NoResult, NoResult);
  endtask

  // Receiver stall pattern, independent of the sender.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 8'd1;
    if (stall_cycle == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      StallNone: begin
        result_stall <= 1'b0;
      end
      StallLight: begin
        result_stall <= ($urandom_range(0, 3) == 0);
      end
      StallHeavy: begin
        result_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 10);
          result_stall <= ~result_stall;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // Each accepted result transaction is scored against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h/%0d/%b/%b",
                                  component, status, run_last, oid_end));
      end else begin
        want = decoded_q.pop_front();
        if (component !== want.component || status !== want.status ||
            run_last !== want.run_last || oid_end !== want.oid_end)
          report_mismatch($sformatf("got %h/%0d/%b/%b, want %h/%0d/%b/%b",
                                    component, status, run_last, oid_end,
                                    want.component, want.status, want.run_last,
                                    want.oid_end));
      end
    end
  end

  initial begin
    // Directed table: typed results where they are plain, the rest from the model.
    add_row(8'h05, 1'b0, 1'b0, 1,
            make_result(32'd5, odb_pkg::StOk, 1'b1, 1'b0), NoResult);
    add_row(8'h00, 1'b1, 1'b0, 2, make_result(32'd0, odb_pkg::StOk, 1'b0, 1'b0),
            make_result(32'd0, odb_pkg::StOk, 1'b1, 1'b0));
    add_row(8'hff, 1'b1, 1'b0, 2, make_result(32'd6, odb_pkg::StOk, 1'b0, 1'b0),
            make_result(32'd15, odb_pkg::StOk, 1'b1, 1'b0));
    add_row(8'h7f, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h80, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h00, 1'b0, 1'b1, Predicted, NoResult, NoResult);
    // Largest component that fits.
    add_row(8'hff, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'hff, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'hff, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h7f, 1'b0, 1'b0, 1,
            make_result(32'h0fff_ffff, odb_pkg::StOk, 1'b1, 1'b0), NoResult);
    // Component too long, then the dropped tail up to the final byte.
    repeat (4) add_row(8'h80, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h80, 1'b0, 1'b0, 1,
            make_result(32'd0, odb_pkg::StTooLong, 1'b1, 1'b1), NoResult);
    add_row(8'h05, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h06, 1'b0, 1'b1, Predicted, NoResult, NoResult);
    // A byte with no first mark after an ended identifier.
    add_row(8'h07, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h85, 1'b0, 1'b1, 1,
            make_result(32'd0, odb_pkg::StUnfinished, 1'b1, 1'b1), NoResult);
    // First and final together, with a first byte in the arc 2 range.
    add_row(8'h50, 1'b1, 1'b1, 2, make_result(32'd2, odb_pkg::StOk, 1'b0, 1'b0),
            make_result(32'd0, odb_pkg::StOk, 1'b1, 1'b1));
    // A first byte arrives while a component is still open; that component gives no result.
    add_row(8'h2b, 1'b1, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h80, 1'b0, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h06, 1'b1, 1'b0, Predicted, NoResult, NoResult);
    add_row(8'h01, 1'b0, 1'b1, Predicted, NoResult, NoResult);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      push_byte(dir_rows[i].data, dir_rows[i].first, dir_rows[i].last,
                dir_rows[i].typed_n, dir_rows[i].r0, dir_rows[i].r1);

    items_done = 0;
    while (items_done < RandomItems) send_random_oid();
    byte_valid <= 1'b0;

    // Drain the outstanding results, then let the bench idle before the final check.
    drain_cycles = 0;
    while (decoded_q.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
    if (errors == 0) begin
      $display("oid_der_body_decoder_top: match");
    end else begin
      $display("oid_der_body_decoder_top: mismatch");
    end
    $finish;
  end

endmodule
